// ----- hdl/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// tms_pkg
// Shared constants and types for the triangle mesh statistics block.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int OUT_AREA_W = 64;
	localparam int OUT_LEN_W  = 18;
	localparam int OUT_CNT_W  = 32;
	localparam logic [OUT_LEN_W-1:0] LEN_MAX = '1;

	// result beat
	typedef struct packed {
		logic [OUT_AREA_W-1:0] area_total;
		logic [OUT_LEN_W-1:0]  mean_edge_len;
		logic [OUT_LEN_W-1:0]  longest_edge_len;
		logic [OUT_CNT_W-1:0]  face_count;
	} tms_result_t;

endpackage

// ----- hdl/tms_if.sv -----
// ----------------------------------------------------------------------------
// tms_tri_if / tms_res_if
// Valid/ready channels for triangle input beats and result beats.
// ----------------------------------------------------------------------------
interface tms_tri_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	logic last;
	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last, input ready);
	modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last, output ready);
endinterface

interface tms_res_if;
	logic valid;
	logic ready;
	logic [63:0] area_total;
	logic [17:0] mean_edge_len;
	logic [17:0] longest_edge_len;
	logic [31:0] face_count;
	modport source (output valid, area_total, mean_edge_len, longest_edge_len,
		face_count, input ready);
	modport sink   (input valid, area_total, mean_edge_len, longest_edge_len,
		face_count, output ready);
endinterface

// ----- hdl/tms_root.sv -----
// ----------------------------------------------------------------------------
// tms_root
// Shared iterative unit: floor square root of a 128-bit radicand, one result
// bit per cycle (restoring method), or restoring division of a 64-bit dividend
// by a divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tms_root (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         is_div,
	input  logic [127:0] opa,
	input  logic [63:0]  opb,
	output logic         done,
	output logic [63:0]  result
);
	logic [127:0] rad_q;
	logic [65:0]  rem_q;
	logic [63:0]  res_q;
	logic [63:0]  dvs_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         div_q;
	logic [65:0]  trial;
	logic [65:0]  sub;
	logic [66:0]  diff;

	// one step: root shifts in two bits, division shifts in one
	always_comb begin
		if (div_q) begin
			trial = {rem_q[64:0], rad_q[127]};
			sub   = {2'b00, dvs_q};
		end else begin
			trial = {rem_q[63:0], rad_q[127:126]};
			sub   = {res_q, 2'b01};
		end
		diff = {1'b0, trial} - {1'b0, sub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= opa;
			dvs_q <= opb;
			div_q <= is_div;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			rad_q <= div_q ? {rad_q[126:0], 1'b0} : {rad_q[125:0], 2'b00};
			if (!diff[66]) begin
				rem_q <= diff[65:0];
				res_q <= {res_q[62:0], 1'b1};
			end else begin
				rem_q <= trial;
				res_q <= {res_q[62:0], 1'b0};
			end
		end
	end

	assign result = res_q;
endmodule

// ----- hdl/triangle_mesh_statistics.sv -----
// ----------------------------------------------------------------------------
// triangle_mesh_statistics
// Accumulates area and edge statistics of a triangle mesh.
// ----------------------------------------------------------------------------
// Usage: one triangle per input beat on tri_in (three signed vertices and a
// last flag). Each triangle runs through a sequencer around one shared
// 64-step root/divide unit: a difference step, the six cross-product
// multiplies, then square roots for the area norm and each edge, each summing
// the squares of three components, then a start, the wait until done and an
// accumulate step. tri_in.ready is low from an accepted beat until the
// sequencer is idle again, so a new triangle is taken only once the last is
// through. A beat with last set also runs one division for the mean edge
// length; its result beat then goes to res_out, and the accumulators clear. A
// result beat waits in its output register while res_out.ready is low; the
// next triangle is still accepted, and the following result (with
// tri_in.ready) waits until that register is free. Cross terms use a small
// signed multiplier and norms a squarer, one product each per cycle. Reset
// (arst_n low) clears the area and length sums, longest edge and face count.
module triangle_mesh_statistics #(
	parameter int COORD_BITS = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	tms_tri_if.sink   tri_in,
	tms_res_if.source res_out
);
	import tms_pkg::*;

	localparam int DW = COORD_BITS + 1;     // difference width
	localparam int CW = 2 * DW + 1;         // cross component width

	localparam logic [3:0] S_IDLE = 4'd0, S_DIFF = 4'd1, S_CROSS = 4'd2,
		S_SQ = 4'd3, S_ROOT = 4'd4, S_WAIT = 4'd5, S_ACC = 4'd6,
		S_DIV = 4'd7, S_DWAIT = 4'd8, S_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] step_q;
	logic [2:0] job_q;   // 0 area, 1..3 edges
	logic last_q;

	logic signed [COORD_BITS-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, wx_q, wy_q, wz_q;
	logic [CW-1:0] n0_q, n1_q, n2_q;
	logic signed [2*DW:0] prod_a_q;
	logic [127:0] acc_q;

	logic [63:0] area_sum_q, length_sum_q;
	logic [OUT_LEN_W-1:0] longest_q;
	logic [COUNT_BITS-1:0] count_q;

	logic out_valid_q;
	tms_result_t out_q;
	logic emit;

	// shared multiplier: operands chosen by the step counter
	logic signed [DW-1:0] ma, mb;
	logic signed [2*DW-1:0] mp;
	logic [CW-1:0] sq_src;
	logic [CW-2:0] sq_lo, sq_hi;
	logic [2*CW-3:0] part;

	always_comb begin
		ma = '0; mb = '0;
		case (step_q)
			4'd0: begin ma = uy_q; mb = vz_q; end
			4'd1: begin ma = uz_q; mb = vy_q; end
			4'd2: begin ma = uz_q; mb = vx_q; end
			4'd3: begin ma = ux_q; mb = vz_q; end
			4'd4: begin ma = ux_q; mb = vy_q; end
			4'd5: begin ma = uy_q; mb = vx_q; end
			default: ;
		endcase
	end
	assign mp = ma * mb;

	// squaring source for the magnitude accumulation
	logic signed [CW-1:0] sq_sv;
	always_comb begin
		case (step_q[1:0])
			2'd0:    sq_sv = (job_q == 3'd0) ? $signed(n0_q) : CW'(job_q == 3'd1 ? ux_q :
				job_q == 3'd2 ? wx_q : vx_q);
			2'd1:    sq_sv = (job_q == 3'd0) ? $signed(n1_q) : CW'(job_q == 3'd1 ? uy_q :
				job_q == 3'd2 ? wy_q : vy_q);
			default: sq_sv = (job_q == 3'd0) ? $signed(n2_q) : CW'(job_q == 3'd1 ? uz_q :
				job_q == 3'd2 ? wz_q : vz_q);
		endcase
		sq_src = sq_sv[CW-1] ? CW'(-sq_sv) : sq_sv;
		sq_lo  = sq_src[CW-2:0];
		sq_hi  = sq_src[CW-2:0];
		part   = sq_lo * sq_hi;
	end

	logic        root_start, root_div, root_done;
	logic [63:0] root_res;
	logic [127:0] root_a;
	logic [63:0]  root_b;
	logic [COUNT_BITS+1:0] div3;

	assign div3 = {2'b00, count_q} + {1'b0, count_q, 1'b0};
	assign root_a = (state_q == S_DIV) ? {length_sum_q, 64'd0} : acc_q;
	assign root_b = 64'(div3);

	tms_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.is_div (root_div),
		.opa    (root_a),
		.opb    (root_b),
		.done   (root_done),
		.result (root_res)
	);

	assign root_start = (state_q == S_ROOT) || (state_q == S_DIV);
	assign root_div   = (state_q == S_DIV);

	logic [64:0] len_add, area_add;
	logic [OUT_LEN_W-1:0] len_sat;
	assign len_sat  = (root_res > 64'(LEN_MAX)) ? LEN_MAX : root_res[OUT_LEN_W-1:0];
	assign len_add  = {1'b0, length_sum_q} + 65'(len_sat);
	assign area_add = {1'b0, area_sum_q} + {2'b00, root_res[63:1]};

	assign tri_in.ready = (state_q == S_IDLE);

	// result register takes a new beat when empty or draining this cycle
	assign emit = (state_q == S_EMIT) && (!out_valid_q || res_out.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= '0;
			job_q        <= '0;
			last_q       <= 1'b0;
			area_sum_q   <= '0;
			length_sum_q <= '0;
			longest_q    <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (res_out.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (tri_in.valid) begin
					last_q  <= tri_in.last;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					step_q  <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5) begin
						step_q  <= '0;
						job_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd2)
						state_q <= S_ROOT;
				end
				S_ROOT: state_q <= S_WAIT;
				S_WAIT: if (root_done) state_q <= S_ACC;
				S_ACC: begin
					if (job_q == 3'd0) begin
						area_sum_q <= area_add[64] ? '1 : area_add[63:0];
					end else begin
						length_sum_q <= len_add[64] ? '1 : len_add[63:0];
						if (len_sat > longest_q)
							longest_q <= len_sat;
					end
					step_q <= '0;
					if (job_q == 3'd3) begin
						if (count_q != '1)
							count_q <= count_q + COUNT_BITS'(1);
						state_q <= last_q ? S_DIV : S_IDLE;
					end else begin
						job_q   <= job_q + 3'd1;
						state_q <= S_SQ;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: if (root_done) state_q <= S_EMIT;
				S_EMIT: if (emit) begin
					area_sum_q   <= '0;
					length_sum_q <= '0;
					longest_q    <= '0;
					count_q      <= '0;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && tri_in.valid) begin
			ax_q <= tri_in.ax; ay_q <= tri_in.ay; az_q <= tri_in.az;
			bx_q <= tri_in.bx; by_q <= tri_in.by; bz_q <= tri_in.bz;
			cx_q <= tri_in.cx; cy_q <= tri_in.cy; cz_q <= tri_in.cz;
		end
		if (state_q == S_DIFF) begin
			ux_q <= DW'(bx_q) - DW'(ax_q); uy_q <= DW'(by_q) - DW'(ay_q);
			uz_q <= DW'(bz_q) - DW'(az_q);
			vx_q <= DW'(cx_q) - DW'(ax_q); vy_q <= DW'(cy_q) - DW'(ay_q);
			vz_q <= DW'(cz_q) - DW'(az_q);
			wx_q <= DW'(cx_q) - DW'(bx_q); wy_q <= DW'(cy_q) - DW'(by_q);
			wz_q <= DW'(cz_q) - DW'(bz_q);
		end
		if (state_q == S_CROSS) begin
			if (!step_q[0])
				prod_a_q <= {mp[2*DW-1], mp};
			else begin
				case (step_q)
					4'd1:    n0_q <= CW'(prod_a_q) - CW'(mp);
					4'd3:    n1_q <= CW'(prod_a_q) - CW'(mp);
					default: n2_q <= CW'(prod_a_q) - CW'(mp);
				endcase
			end
		end
		if (state_q == S_SQ)
			acc_q <= ((step_q == 4'd0) ? 128'd0 : acc_q) + 128'(part);
		if (emit) begin
			out_q.area_total       <= area_sum_q;
			out_q.mean_edge_len    <= (root_res > 64'(LEN_MAX)) ? LEN_MAX :
				root_res[OUT_LEN_W-1:0];
			out_q.longest_edge_len <= longest_q;
			out_q.face_count       <= (COUNT_BITS > OUT_CNT_W &&
				(count_q >> OUT_CNT_W) != '0) ? '1 : OUT_CNT_W'(count_q);
		end
	end

	assign res_out.valid            = out_valid_q;
	assign res_out.area_total       = out_q.area_total;
	assign res_out.mean_edge_len    = out_q.mean_edge_len;
	assign res_out.longest_edge_len = out_q.longest_edge_len;
	assign res_out.face_count       = out_q.face_count;
endmodule
